@@ sv/minv_pkg.sv @@
package minv_pkg;

    localparam int ELEM_WIDTH_DEF = 16;
    localparam int ROWS           = 4;
    localparam int COLS           = 4;
    localparam int NUM_COF        = ROWS * COLS;
    // widest element that the arithmetic ever sees
    localparam int CALC_W         = 16;
    localparam int DIFF_W         = 2 * CALC_W + 1;
    localparam int COF_W          = 3 * CALC_W + 3;
    localparam int PROD_W         = CALC_W + COF_W;
    localparam int DET_W          = PROD_W + 3;
    localparam int DMAG_W         = 64;
    localparam int QUOT_SHIFT     = 36;
    localparam int NUM_W          = COF_W + QUOT_SHIFT;
    localparam int Q_W            = 40;
    localparam int OUT_W          = 32;
    localparam int THR_W          = 32;
    localparam int STEP_COF       = 8;
    localparam int STEP_DET       = 9;

    typedef enum logic [2:0] {
        OP_DSET,
        OP_DSUB,
        OP_ADD,
        OP_SUB,
        OP_DET
    } t_op;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_RD,
        CS_MUL,
        CS_ACC
    } t_cstate;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COF,
        ST_CHK,
        ST_DSTART,
        ST_DWAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0] row_a;
        logic [1:0] col_a;
        logic [1:0] row_b;
        logic [1:0] col_b;
        t_op        op;
    } t_uop;

    typedef struct packed {
        logic                    adj_we;
        logic [3:0]              adj_idx;
        logic signed [COF_W-1:0] adj_val;
        logic                    done;
    } t_cof_stat;

    // n-th index of 0..3 once x is left out
    function automatic logic [1:0] skip(input logic [1:0] x, input logic [1:0] n);
        return (n < x) ? n : n + 2'd1;
    endfunction

    // Micro-step s of cofactor k = row*4 + col. The cofactor at (r, c) is the
    // minor with row c and column r removed; three terms of two steps for the
    // 2x2 difference and one step for the outer product, then the
    // determinant step for column-0 cofactors.
    function automatic t_uop uop(input logic [3:0] k, input logic [3:0] s);
        logic [1:0] rr;
        logic [1:0] cc;
        logic [1:0] t;
        logic [1:0] ca;
        logic [1:0] cb;
        logic [1:0] cm;
        t_uop       u;
        rr = k[3:2];
        cc = k[1:0];
        t  = (s >= 4'd6) ? 2'd2 : (s >= 4'd3) ? 2'd1 : 2'd0;
        cm = skip(rr, t);
        ca = skip(rr, (t == 2'd0) ? 2'd1 : 2'd0);
        cb = skip(rr, (t == 2'd2) ? 2'd1 : 2'd2);
        u  = '{row_a: skip(cc, 2'd1), col_a: ca, row_b: skip(cc, 2'd2), col_b: cb,
               op: OP_DSET};
        case (s)
            4'd0, 4'd3, 4'd6: begin
                u.op = OP_DSET;
            end
            4'd1, 4'd4, 4'd7: begin
                u.col_a = cb;
                u.col_b = ca;
                u.op    = OP_DSUB;
            end
            4'd2, 4'd5, 4'd8: begin
                u.row_a = skip(cc, 2'd0);
                u.col_a = cm;
                u.op    = (t == 2'd1) ? OP_SUB : OP_ADD;
            end
            default: begin
                u.row_a = 2'd0;
                u.col_a = rr;
                u.op    = OP_DET;
            end
        endcase
        return u;
    endfunction

endpackage

@@ sv/matrix_inverse_4x4_top.sv @@
// 4x4 matrix inverse by cofactors and adjugate. Send the matrix one row per
// request (signed Q4.12 elements, row_index 0..3); rows 0 to 2 are stored
// and give no result. A row 3 request stores its row and runs the inversion
// on the stored matrix, during which the input is not ready. The sixteen
// cofactors and the determinant are formed exactly by one shared multiplier
// under a micro-step sequencer: 148 multiply steps, each of read, multiply
// and accumulate. A determinant whose magnitude, in units of 2^-48, is zero
// or below singular_threshold yields a single result with singular set.
// Otherwise each of the 16 inverse elements goes through one bit-serial
// restoring divider of 87 steps plus start and rounding cycles, and each
// result waits on i_out_ready. Each of the four results carries one row of
// the inverse in signed Q8.24, rounded to nearest with ties away from zero;
// clipped elements set saturated. Write singular_threshold only while the
// block is idle.
module matrix_inverse_4x4_top #(
    parameter int ELEM_WIDTH = minv_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_row_index,
    input  logic signed [15:0]                  i_col0,
    input  logic signed [15:0]                  i_col1,
    input  logic signed [15:0]                  i_col2,
    input  logic signed [15:0]                  i_col3,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_out_row,
    output logic signed [31:0]                  o_inv_col0,
    output logic signed [31:0]                  o_inv_col1,
    output logic signed [31:0]                  o_inv_col2,
    output logic signed [31:0]                  o_inv_col3,
    output logic                                o_singular,
    output logic                                o_saturated,
    output logic                                o_last_row,
    input  logic                                i_cfg_we,
    input  logic [minv_pkg::THR_W-1:0]          i_cfg_wdata
);
    import minv_pkg::*;

    localparam int EFF_W = (ELEM_WIDTH < CALC_W) ? ELEM_WIDTH : CALC_W;
    localparam int SHL   = CALC_W - EFF_W;

    t_state                   r_state, n_state;
    logic [THR_W-1:0]         r_thr;
    logic                     in_acc;
    logic signed [CALC_W-1:0] fld   [COLS];
    logic signed [CALC_W-1:0] trunc [COLS];
    logic [4*ELEM_WIDTH-1:0]  wrow;
    logic [4*ELEM_WIDTH-1:0]  row_a;
    logic [4*ELEM_WIDTH-1:0]  row_b;
    logic [1:0]               raddr_a;
    logic [1:0]               raddr_b;
    t_cof_stat                cstat;
    logic signed [DET_W-1:0]  det;
    logic [DMAG_W-1:0]        dmag;
    logic                     sing;
    logic signed [COF_W-1:0]  r_adj [NUM_COF];
    logic signed [COF_W-1:0]  adj_e;
    logic [DMAG_W-1:0]        r_dmag;
    logic                     r_dneg;
    logic [3:0]               r_e;
    logic                     div_done;
    logic [OUT_W-1:0]         div_quot;
    logic                     div_sat;
    logic [1:0]               r_out_row;
    logic [OUT_W-1:0]         r_inv [COLS];
    logic                     r_sing;
    logic                     r_sat;
    logic                     r_last;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_row   = r_out_row;
    assign o_inv_col0  = r_inv[0];
    assign o_inv_col1  = r_inv[1];
    assign o_inv_col2  = r_inv[2];
    assign o_inv_col3  = r_inv[3];
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;
    assign o_last_row  = r_last;

    // keep the low EFF_W bits of each element, sign-extended to storage width
    always_comb begin
        fld[0] = i_col0;
        fld[1] = i_col1;
        fld[2] = i_col2;
        fld[3] = i_col3;
        for (int c = 0; c < COLS; c++) begin
            trunc[c] = (fld[c] <<< SHL) >>> SHL;
            wrow[c*ELEM_WIDTH +: ELEM_WIDTH] = ELEM_WIDTH'(trunc[c]);
        end
    end

    // two copies of the matrix store so a multiply step reads two elements
    minv_ram #(.WIDTH(4*ELEM_WIDTH), .DEPTH(ROWS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (i_row_index),
        .i_wdata (wrow),
        .i_raddr (raddr_a),
        .o_rdata (row_a)
    );

    minv_ram #(.WIDTH(4*ELEM_WIDTH), .DEPTH(ROWS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (i_row_index),
        .i_wdata (wrow),
        .i_raddr (raddr_b),
        .o_rdata (row_b)
    );

    minv_cof #(.ELEM_WIDTH(ELEM_WIDTH)) u_cof (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc && i_row_index == 2'd3),
        .i_row_a   (row_a),
        .i_row_b   (row_b),
        .o_raddr_a (raddr_a),
        .o_raddr_b (raddr_b),
        .o_stat    (cstat),
        .o_det     (det)
    );

    // determinant: sign from the exact sum, magnitude kept to 64 bits
    assign dmag  = det[DET_W-1] ? DMAG_W'(-det[DMAG_W-1:0]) : det[DMAG_W-1:0];
    assign sing  = (dmag == '0) || (dmag < DMAG_W'(r_thr));
    assign adj_e = r_adj[r_e];

    minv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DSTART),
        .i_num   (adj_e[COF_W-1] ? COF_W'(-adj_e) : COF_W'(adj_e)),
        .i_den   (r_dmag),
        .i_neg   (adj_e[COF_W-1] ^ r_dneg),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_sat   (div_sat)
    );

    // sequencer: load rows, wait for cofactors, check, divide, hand out rows
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_row_index == 2'd3) begin
                    n_state = ST_COF;
                end
            end
            ST_COF: begin
                if (cstat.done) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                n_state = sing ? ST_OUT : ST_DSTART;
            end
            ST_DSTART: begin
                n_state = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    n_state = (r_e[1:0] == 2'd3) ? ST_OUT : ST_DSTART;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = r_last ? ST_IDLE : ST_DSTART;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_thr   <= THR_W'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cstat.adj_we) begin
            r_adj[cstat.adj_idx] <= cstat.adj_val;
        end
        case (r_state)
            ST_CHK: begin
                r_dmag <= dmag;
                r_dneg <= det[DET_W-1];
                r_e    <= '0;
                // singular: one all-zero result, flagged and last
                r_out_row <= '0;
                r_sing    <= sing;
                r_sat     <= 1'b0;
                r_last    <= sing;
                for (int c = 0; c < COLS; c++) begin
                    r_inv[c] <= '0;
                end
            end
            ST_DWAIT: begin
                if (div_done) begin
                    r_inv[r_e[1:0]] <= div_quot;
                    r_sat <= ((r_e[1:0] == 2'd0) ? 1'b0 : r_sat) | div_sat;
                    if (r_e[1:0] == 2'd3) begin
                        r_out_row <= r_e[3:2];
                        r_last    <= (r_e == 4'(NUM_COF - 1));
                    end else begin
                        r_e <= r_e + 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (i_out_ready && !r_last) begin
                    r_e <= r_e + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    a_no_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    a_singular_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> o_last_row && o_out_row == 2'd0 && !o_saturated)
        else $error("singular result not alone");

    a_row3_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_row_index == 2'd3 |=> !o_in_ready)
        else $error("ready after row 3 request");

    a_last_row_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_singular |-> (o_last_row == (o_out_row == 2'd3)))
        else $error("last_row out of place");

endmodule

@@ sv/minv_ram.sv @@
module minv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/minv_div.sv @@
module minv_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [minv_pkg::COF_W-1:0]      i_num,
    input  logic [minv_pkg::DMAG_W-1:0]     i_den,
    input  logic                            i_neg,
    output logic                            o_done,
    output logic [minv_pkg::OUT_W-1:0]      o_quot,
    output logic                            o_sat
);
    import minv_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic               r_busy;
    logic               r_fin;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_num;
    logic [DMAG_W-1:0]  r_rem;
    logic [DMAG_W-1:0]  r_den;
    logic [Q_W-1:0]     r_q;
    logic               r_big;
    logic               r_neg;
    logic [DMAG_W:0]    rem2;
    logic               ge;
    logic [DMAG_W-1:0]  rem_n;
    logic               rnd;
    logic [Q_W:0]       qr;
    logic [Q_W:0]       lim;
    logic               sat;
    logic [Q_W:0]       mag;

    always_comb begin
        rem2  = {r_rem, r_num[NUM_W-1]};
        ge    = rem2 >= {1'b0, r_den};
        rem_n = ge ? DMAG_W'(rem2 - {1'b0, r_den}) : rem2[DMAG_W-1:0];
        // round half away from zero on the magnitude
        rnd   = r_rem >= (r_den - r_rem);
        qr    = {1'b0, r_q} + (Q_W+1)'(rnd);
        lim   = r_neg ? (Q_W+1)'(64'h8000_0000) : (Q_W+1)'(64'h7FFF_FFFF);
        sat   = r_big || (qr > lim);
        mag   = sat ? lim : qr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NUM_W'(i_num) << QUOT_SHIFT;
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= '0;
            r_big <= 1'b0;
            r_neg <= i_neg;
            r_cnt <= CNT_W'(NUM_W - 1);
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= rem_n;
            r_q   <= {r_q[Q_W-2:0], ge};
            r_big <= r_big | (ge && (r_cnt >= CNT_W'(Q_W)));
            r_cnt <= r_cnt - 1'b1;
        end
        if (r_fin) begin
            o_quot <= r_neg ? OUT_W'(-mag[OUT_W-1:0]) : mag[OUT_W-1:0];
            o_sat  <= sat;
        end
    end

endmodule

@@ sv/minv_cof.sv @@
module minv_cof #(
    parameter int ELEM_WIDTH = minv_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [4*ELEM_WIDTH-1:0]             i_row_a,
    input  logic [4*ELEM_WIDTH-1:0]             i_row_b,
    output logic [1:0]                          o_raddr_a,
    output logic [1:0]                          o_raddr_b,
    output minv_pkg::t_cof_stat                 o_stat,
    output logic signed [minv_pkg::DET_W-1:0]   o_det
);
    import minv_pkg::*;

    t_cstate                  r_state, n_state;
    logic [3:0]               r_k, n_k;
    logic [3:0]               r_s, n_s;
    logic signed [DIFF_W-1:0] r_d, n_d;
    logic signed [COF_W-1:0]  r_acc, n_acc;
    logic signed [COF_W-1:0]  r_cof, n_cof;
    logic signed [DET_W-1:0]  r_det, n_det;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_done, n_done;
    t_uop                     u;
    logic [ELEM_WIDTH-1:0]    wa;
    logic [ELEM_WIDTH-1:0]    wb;
    logic signed [CALC_W-1:0] ea;
    logic signed [CALC_W-1:0] eb;
    logic signed [COF_W-1:0]  opb;
    logic signed [COF_W-1:0]  sum;
    logic signed [COF_W-1:0]  cof;
    logic                     adv;

    assign u         = uop(r_k, r_s);
    assign o_raddr_a = u.row_a;
    assign o_raddr_b = u.row_b;
    assign wa        = i_row_a[u.col_a*ELEM_WIDTH +: ELEM_WIDTH];
    assign wb        = i_row_b[u.col_b*ELEM_WIDTH +: ELEM_WIDTH];
    assign ea        = CALC_W'($signed(wa));
    assign eb        = CALC_W'($signed(wb));
    assign o_det     = r_det;

    always_comb begin
        case (u.op)
            OP_DSET, OP_DSUB: opb = COF_W'(eb);
            OP_ADD, OP_SUB:   opb = COF_W'(r_d);
            default:          opb = r_cof;
        endcase
        sum = (u.op == OP_SUB) ? r_acc - COF_W'(r_prod) : r_acc + COF_W'(r_prod);
        // checkerboard sign of the adjugate
        cof = (r_k[2] ^ r_k[0]) ? -sum : sum;
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_s     = r_s;
        n_d     = r_d;
        n_acc   = r_acc;
        n_cof   = r_cof;
        n_det   = r_det;
        n_done  = 1'b0;
        adv     = 1'b0;
        o_stat  = '{adj_we: 1'b0, adj_idx: r_k, adj_val: cof, done: r_done};
        case (r_state)
            CS_IDLE: begin
                if (i_start) begin
                    n_k     = '0;
                    n_s     = '0;
                    n_acc   = '0;
                    n_det   = '0;
                    n_state = CS_RD;
                end
            end
            CS_RD: begin
                n_state = CS_MUL;
            end
            CS_MUL: begin
                n_state = CS_ACC;
            end
            CS_ACC: begin
                n_state = CS_RD;
                case (u.op)
                    OP_DSET:        n_d   = DIFF_W'(r_prod);
                    OP_DSUB:        n_d   = r_d - DIFF_W'(r_prod);
                    OP_ADD, OP_SUB: n_acc = sum;
                    default:        n_det = r_det + DET_W'(r_prod);
                endcase
                if (r_s == 4'(STEP_COF)) begin
                    o_stat.adj_we = 1'b1;
                    n_cof         = cof;
                    n_acc         = '0;
                    if (r_k[1:0] == 2'd0) begin
                        n_s = 4'(STEP_DET);
                    end else begin
                        adv = 1'b1;
                    end
                end else if (r_s == 4'(STEP_DET)) begin
                    adv = 1'b1;
                end else begin
                    n_s = r_s + 1'b1;
                end
                if (adv) begin
                    if (r_k == 4'(NUM_COF - 1)) begin
                        n_state = CS_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_s = '0;
                    end
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_s   <= n_s;
        r_d   <= n_d;
        r_acc <= n_acc;
        r_cof <= n_cof;
        r_det <= n_det;
        if (r_state == CS_MUL) begin
            r_prod <= PROD_W'(ea) * PROD_W'(opb);
        end
    end

endmodule

@@ tb/sv/matrix_inverse_4x4_checker.sv @@
`timescale 1ns / 1ps

module matrix_inverse_4x4_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_row_index,
    input  logic signed [15:0] i_col0,
    input  logic signed [15:0] i_col1,
    input  logic signed [15:0] i_col2,
    input  logic signed [15:0] i_col3,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_out_row,
    input  logic signed [31:0] i_inv_col0,
    input  logic signed [31:0] i_inv_col1,
    input  logic signed [31:0] i_inv_col2,
    input  logic signed [31:0] i_inv_col3,
    input  logic               i_singular,
    input  logic               i_saturated,
    input  logic               i_last_row,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_rows_pending
);

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        logic        sing;
        logic        sat;
        logic        last;
    } t_inv_row;

    t_inv_row     inv_rows_q[$];
    logic signed [15:0] mat[16];
    logic [31:0]  thresh;
    int           fails;

    assign o_fail_count   = fails;
    assign o_rows_pending = inv_rows_q.size();

    function automatic longint cell_at(input int r, input int c);
        return longint'(mat[r * 4 + c]);
    endfunction

    // 3x3 determinant with row dr and column dc removed
    function automatic longint minor_det(input int dr, input int dc);
        int rs[3];
        int cs[3];
        int n;
        int k;
        n = 0;
        k = 0;
        for (int i = 0; i < 4; i++) begin
            if (i != dr) begin rs[n] = i; n++; end
            if (i != dc) begin cs[k] = i; k++; end
        end
        return cell_at(rs[0], cs[0]) * (cell_at(rs[1], cs[1]) * cell_at(rs[2], cs[2])
                 - cell_at(rs[1], cs[2]) * cell_at(rs[2], cs[1]))
             - cell_at(rs[0], cs[1]) * (cell_at(rs[1], cs[0]) * cell_at(rs[2], cs[2])
                 - cell_at(rs[1], cs[2]) * cell_at(rs[2], cs[0]))
             + cell_at(rs[0], cs[2]) * (cell_at(rs[1], cs[0]) * cell_at(rs[2], cs[1])
                 - cell_at(rs[1], cs[1]) * cell_at(rs[2], cs[0]));
    endfunction

    // one Q8.24 element: cofactor * 2^36 / det, rounded, saturated
    function automatic logic [32:0] inv_elem(input longint cf, input bit dneg,
                                             input logic [63:0] dmag);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        logic [63:0]  cmag;
        logic [63:0]  lim;
        bit           neg;
        cmag = (cf < 0) ? 64'(-cf) : 64'(cf);
        neg  = (cf < 0) != dneg;
        lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (cmag == 0) return 33'd0;
        num = {64'd0, cmag} << 36;
        q = num / {64'd0, dmag};
        r = num % {64'd0, dmag};
        if (r >= {64'd0, dmag} - r) q++;
        if (q > {64'd0, lim}) return {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
        return {1'b0, neg ? 32'(-q[31:0]) : q[31:0]};
    endfunction

    task automatic predict_inverse();
        longint      adj[16];
        logic [127:0] det;
        logic [63:0]  dmag;
        bit           dneg;
        t_inv_row     e;
        logic [32:0]  v[4];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                adj[r * 4 + c] = ((r + c) % 2) ? -minor_det(c, r) : minor_det(c, r);
        det = '0;
        for (int j = 0; j < 4; j++)
            det += 128'(signed'(cell_at(0, j) * adj[j * 4]));
        dneg = det[127];
        dmag = dneg ? 64'(-det) : det[63:0];
        if (dmag == 0 || dmag < {32'd0, thresh}) begin
            e = '0;
            e.sing = 1'b1;
            e.last = 1'b1;
            inv_rows_q.push_back(e);
            return;
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) v[c] = inv_elem(adj[r * 4 + c], dneg, dmag);
            e.row  = 2'(r);
            e.c0   = v[0][31:0];
            e.c1   = v[1][31:0];
            e.c2   = v[2][31:0];
            e.c3   = v[3][31:0];
            e.sing = 1'b0;
            e.sat  = v[0][32] | v[1][32] | v[2][32] | v[3][32];
            e.last = (r == 3);
            inv_rows_q.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_inv_row got;
        t_inv_row want;
        if (!i_rst_n) begin
            thresh = 32'd1;
            fails  = 0;
            inv_rows_q.delete();
        end else begin
            if (i_cfg_we) thresh = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                mat[i_row_index * 4 + 0] = i_col0;
                mat[i_row_index * 4 + 1] = i_col1;
                mat[i_row_index * 4 + 2] = i_col2;
                mat[i_row_index * 4 + 3] = i_col3;
                if (i_row_index == 2'd3) predict_inverse();
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_row, i_inv_col0, i_inv_col1, i_inv_col2, i_inv_col3,
                        i_singular, i_saturated, i_last_row};
                if (inv_rows_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result row %0d", i_out_row);
                end else begin
                    want = inv_rows_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch exp row %0d %h %h %h %h s%b t%b l%b got row %0d %h %h %h %h s%b t%b l%b",
                                     want.row, want.c0, want.c1, want.c2, want.c3,
                                     want.sing, want.sat, want.last,
                                     got.row, got.c0, got.c1, got.c2, got.c3,
                                     got.sing, got.sat, got.last);
                    end
                end
            end
        end
    end

endmodule

@@ tb/sv/matrix_inverse_4x4_top_tb.sv @@
`timescale 1ns / 1ps

module matrix_inverse_4x4_top_tb;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         row_index;
    logic signed [15:0] col[4];
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         out_row;
    logic signed [31:0] inv_col[4];
    logic               singular;
    logic               saturated;
    logic               last_row;
    logic               cfg_we;
    logic [31:0]        cfg_wdata;
    int                 fail_count;
    int                 rows_pending;
    int                 idle_cycles;
    bit                 calm;
    bit                 timed_out;

    localparam int WATCHDOG_LIMIT = 40000;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    matrix_inverse_4x4_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_row_index(row_index),
        .i_col0(col[0]), .i_col1(col[1]), .i_col2(col[2]), .i_col3(col[3]),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_row(out_row),
        .o_inv_col0(inv_col[0]), .o_inv_col1(inv_col[1]),
        .o_inv_col2(inv_col[2]), .o_inv_col3(inv_col[3]),
        .o_singular(singular), .o_saturated(saturated), .o_last_row(last_row),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    matrix_inverse_4x4_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_row_index(row_index),
        .i_col0(col[0]), .i_col1(col[1]), .i_col2(col[2]), .i_col3(col[3]),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_row(out_row),
        .i_inv_col0(inv_col[0]), .i_inv_col1(inv_col[1]),
        .i_inv_col2(inv_col[2]), .i_inv_col3(inv_col[3]),
        .i_singular(singular), .i_saturated(saturated), .i_last_row(last_row),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_rows_pending(rows_pending)
    );

    // Stall the result side about 13% of cycles, except in calm stretches.
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 13);
    end

    // Count cycles with no accepted request or result; give up at the limit.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Send one row request, optionally idling first; hold it until accepted.
    // Valid stays high on return, so the caller's next drive decides it.
    task automatic send_row(input logic [1:0] r, input logic [15:0] a,
                            input logic [15:0] b, input logic [15:0] c,
                            input logic [15:0] d);
        while (!calm && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        row_index <= r;
        col[0]    <= a;
        col[1]    <= b;
        col[2]    <= c;
        col[3]    <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_elem(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(8191)) - 16'd4096;
            default: return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    // Send a full matrix: rows 0..2 in shuffled order, then row 3.
    task automatic send_matrix(input int mode);
        int ord[3];
        int t;
        int j;
        ord = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
            j = $urandom_range(i);
            t = ord[i]; ord[i] = ord[j]; ord[j] = t;
        end
        for (int i = 0; i < 3; i++)
            send_row(2'(ord[i]), rand_elem(mode), rand_elem(mode),
                     rand_elem(mode), rand_elem(mode));
        send_row(2'd3, rand_elem(mode), rand_elem(mode), rand_elem(mode), rand_elem(mode));
    endtask

    // Drop valid and drain expected results.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0) @(posedge clk);
    endtask

    // Drain expected results, let the divider finish, then write the threshold.
    task automatic set_threshold(input logic [31:0] v);
        drain();
        repeat (2500) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        row_index <= '0;
        col       <= '{default: '0};
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        calm      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, scaled identity, extremes, zero det, repeated row 3.
        send_row(2'd0, 16'h1000, 16'h0000, 16'h0000, 16'h0000);
        send_row(2'd1, 16'h0000, 16'h1000, 16'h0000, 16'h0000);
        send_row(2'd2, 16'h0000, 16'h0000, 16'h1000, 16'h0000);
        send_row(2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
        send_row(2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
        send_row(2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
        send_row(2'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_row(2'd1, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
        send_row(2'd2, 16'h0001, 16'h0000, 16'h7FFF, 16'hFFFF);
        send_row(2'd3, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF);
        send_row(2'd3, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_row(2'd0, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_row(2'd1, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
        send_row(2'd2, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
        send_row(2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0001);

        // Threshold extremes: zero, all ones, then random and back to one.
        set_threshold(32'd0);
        send_row(2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_row(2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0002);
        set_threshold(32'hFFFF_FFFF);
        send_matrix(1);
        send_matrix(0);
        send_row(2'd0, 16'h1000, 16'h0000, 16'h0000, 16'h0000);
        send_row(2'd1, 16'h0000, 16'h1000, 16'h0000, 16'h0000);
        send_row(2'd2, 16'h0000, 16'h0000, 16'h1000, 16'h0000);
        send_row(2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h1000);

        // Random: mostly well-formed matrices, some stray row 3 repeats.
        for (int ph = 0; ph < 4; ph++) begin
            set_threshold(ph == 3 ? 32'd1 : 32'($urandom));
            calm = (ph == 1);
            for (int m = 0; m < 20; m++) begin
                if ($urandom_range(9) == 0)
                    send_row(2'd3, rand_elem(0), rand_elem(0), rand_elem(0), rand_elem(0));
                else
                    send_matrix($urandom_range(2));
            end
        end
        calm = 1'b0;

        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
